>>> sv/multi_lane_i2c_angle_reader_defines.svh
// Assertion macros shared by the reader's modules.
`ifndef MULTI_LANE_I2C_ANGLE_READER_DEFINES_SVH
`define MULTI_LANE_I2C_ANGLE_READER_DEFINES_SVH

`ifndef SYNTHESIS
`define MLAR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MLAR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MLAR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MLAR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/mlar_pkg.sv
`default_nettype none

package mlar_pkg;

   localparam int LANE_MAX      = 8;
   localparam int LANES_DEFAULT = 8;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_ANGLE  = 2'd2;

   localparam logic CSR_LANE_ENABLE    = 1'b0;
   localparam logic CSR_DEVICE_ADDRESS = 1'b1;

   localparam logic [7:0] ENABLE_RESET  = 8'hFF;
   localparam logic [6:0] ADDRESS_RESET = 7'h36;

   localparam logic [7:0] REG_STATUS = 8'h0B;
   localparam logic [7:0] REG_ANGLE  = 8'h0C;

   localparam logic [7:0] STATUS_MD = 8'h20;
   localparam logic [7:0] STATUS_ML = 8'h10;
   localparam logic [7:0] STATUS_MH = 8'h08;

   localparam logic [1:0] MAG_NONE   = 2'd0;
   localparam logic [1:0] MAG_WEAK   = 2'd1;
   localparam logic [1:0] MAG_STRONG = 2'd2;
   localparam logic [1:0] MAG_NORMAL = 2'd3;

   localparam logic [1:0] LINE_NONE = 2'd0;
   localparam logic [1:0] LINE_KEEP = 2'd1;
   localparam logic [1:0] LINE_LOW  = 2'd2;
   localparam logic [1:0] LINE_HIGH = 2'd3;

   localparam logic [7:0] LINES_RELEASED = 8'hFF;

   typedef struct packed {
      logic       clear;
      logic       sample_ack;
      logic       sample_data;
      logic       finish;
      logic       status_read;
      logic [1:0] scl_op;
      logic [1:0] sda_op;
   } lane_ctl_type;

   function automatic logic [1:0] magnet_code(input logic [7:0] d);
      logic [1:0] code;
      if ((d & STATUS_MD) == 8'd0) begin
         code = MAG_NONE;
      end else if ((d & STATUS_ML) != 8'd0) begin
         code = MAG_WEAK;
      end else if ((d & STATUS_MH) != 8'd0) begin
         code = MAG_STRONG;
      end else begin
         code = MAG_NORMAL;
      end
      return code;
   endfunction

   // A lane that is not active is always released by a keep or a low.
   function automatic logic line_next(input logic cur, input logic act, input logic [1:0] op);
      logic lv;
      case (op)
         LINE_NONE: lv = cur;
         LINE_KEEP: lv = cur | ~act;
         LINE_LOW:  lv = ~act;
         LINE_HIGH: lv = 1'b1;
         default:   lv = cur;
      endcase
      return lv;
   endfunction

endpackage

`default_nettype wire

>>> sv/multi_lane_i2c_angle_reader.sv
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tdata sda_in, tuser kind
// rsp       out        rsp_tvalid/rsp_tready   tdata line state and lane report, tuser, tlast
// csr       in         csr_we                  csr_index, csr_wdata
//
// An item is accepted in every cycle while results flow; each item yields one line-state item.
// The stop tick of a read also yields one report item per enabled lane, and the output stage
// holds req_tready low while those drain.
// A low rsp_tready holds the output register and, through it, the input.
// Reset is synchronous and active high; lines come out of reset released.
`default_nettype none

module multi_lane_i2c_angle_reader #(
   parameter int LANES = mlar_pkg::LANES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] sda_in
   input  wire  [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] scl_out, [15:8] sda_out, [16] busy_res,
                                    // [19:17] lane, [20] online, [36:21] angle, [38:37] magnet
   output logic        rsp_tuser,   // [0] report_valid
   output logic        rsp_tlast,   // last
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata
);

   localparam int NL = (LANES > mlar_pkg::LANE_MAX) ? mlar_pkg::LANE_MAX
                     : ((LANES < 1) ? 1 : LANES);

   logic [7:0] enable_ff, enable_in;
   logic [6:0] address_ff, address_in;

   logic                   accept;
   mlar_pkg::lane_ctl_type ctl;
   logic                   busy_next;
   logic [7:0]             en_lanes;
   logic [7:0]             scl_next;
   logic [7:0]             sda_next;
   logic [7:0]             lane_online;
   logic [7:0][15:0]       lane_angle;
   logic [7:0][1:0]        lane_magnet;

   always_comb begin
      enable_in  = enable_ff;
      address_in = address_ff;
      if (csr_we) begin
         case (csr_index)
            mlar_pkg::CSR_LANE_ENABLE:    enable_in  = csr_wdata;
            mlar_pkg::CSR_DEVICE_ADDRESS: address_in = csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= mlar_pkg::ENABLE_RESET;
         address_ff <= mlar_pkg::ADDRESS_RESET;
      end else begin
         enable_ff  <= enable_in;
         address_ff <= address_in;
      end
   end

   assign accept = req_tvalid && req_tready;

   mlar_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_tuser),
      .en_any         (en_lanes != 8'd0),
      .device_address (address_ff),
      .ctl            (ctl),
      .busy_next      (busy_next)
   );

   for (genvar i = 0; i < mlar_pkg::LANE_MAX; i++) begin : g_lane
      if (i < NL) begin : g_used
         assign en_lanes[i] = enable_ff[i];
         mlar_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .enable   (enable_ff[i]),
            .sda_bit  (req_tdata[i]),
            .scl_next (scl_next[i]),
            .sda_next (sda_next[i]),
            .online   (lane_online[i]),
            .angle    (lane_angle[i]),
            .magnet   (lane_magnet[i])
         );
      end else begin : g_unused
         assign en_lanes[i]    = 1'b0;
         assign scl_next[i]    = 1'b1;
         assign sda_next[i]    = 1'b1;
         assign lane_online[i] = 1'b0;
         assign lane_angle[i]  = 16'd0;
         assign lane_magnet[i] = mlar_pkg::MAG_NONE;
      end
   end

   mlar_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .scl_line    (scl_next),
      .sda_line    (sda_next),
      .busy        (busy_next),
      .finish      (ctl.finish),
      .report_mask (en_lanes),
      .lane_online (lane_online),
      .lane_angle  (lane_angle),
      .lane_magnet (lane_magnet),
      .in_ready    (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> sv/mlar_seq.sv
`default_nettype none
`include "multi_lane_i2c_angle_reader_defines.svh"

module mlar_seq (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire  [1:0]            kind,
   input  wire                   en_any,
   input  wire  [6:0]            device_address,
   output mlar_pkg::lane_ctl_type ctl,
   output logic                  busy_next
);

   localparam logic [3:0] SEG_IDLE    = 4'd0;
   localparam logic [3:0] SEG_START   = 4'd1;
   localparam logic [3:0] SEG_ADDRW   = 4'd2;
   localparam logic [3:0] SEG_REG     = 4'd3;
   localparam logic [3:0] SEG_RESTART = 4'd4;
   localparam logic [3:0] SEG_ADDRR   = 4'd5;
   localparam logic [3:0] SEG_DHI     = 4'd6;
   localparam logic [3:0] SEG_DLO     = 4'd7;
   localparam logic [3:0] SEG_STOP    = 4'd8;

   logic [5:0] phase_ff, phase_in;
   logic [3:0] bc_ff, bc_in;
   logic [1:0] cmd_ff, cmd_in;

   logic [3:0] seg;
   logic [1:0] sub;
   logic       is_write;
   logic       bc_hi;
   logic [7:0] tx_byte;
   logic       tx_bit;
   logic       bit_level;
   logic [4:0] bc_plus;
   logic [3:0] seg_after;

   always_comb begin
      seg      = phase_ff[5:2];
      sub      = phase_ff[1:0];
      is_write = (seg == SEG_ADDRW) || (seg == SEG_REG) || (seg == SEG_ADDRR);
      bc_hi    = (bc_ff >= 4'd8);
      case (seg)
         SEG_ADDRW: tx_byte = {device_address, 1'b0};
         SEG_ADDRR: tx_byte = {device_address, 1'b1};
         default:   tx_byte = (cmd_ff == mlar_pkg::KIND_STATUS) ? mlar_pkg::REG_STATUS
                                                               : mlar_pkg::REG_ANGLE;
      endcase
      tx_bit = tx_byte[~bc_ff[2:0]];
      if (is_write && !bc_hi) begin
         bit_level = tx_bit;
      end else if (!is_write && bc_hi) begin
         bit_level = !((seg == SEG_DHI) && (cmd_ff == mlar_pkg::KIND_ANGLE));
      end else begin
         bit_level = 1'b1;
      end
      bc_plus   = {1'b0, bc_ff} + 5'd1;
      seg_after = ((seg == SEG_DHI) && (cmd_ff != mlar_pkg::KIND_ANGLE)) ? SEG_STOP
                                                                        : seg + 4'd1;
   end

   always_comb begin
      phase_in = phase_ff;
      bc_in    = bc_ff;
      cmd_in   = cmd_ff;
      ctl      = '0;
      ctl.status_read = (cmd_ff == mlar_pkg::KIND_STATUS);
      if (accept) begin
         if (kind == mlar_pkg::KIND_STATUS || kind == mlar_pkg::KIND_ANGLE) begin
            if (seg == SEG_IDLE && en_any) begin
               ctl.clear = 1'b1;
               cmd_in    = kind;
               bc_in     = 4'd0;
               phase_in  = {SEG_START, 2'd0};
            end
         end else if (kind == mlar_pkg::KIND_TICK) begin
            case (seg)
               SEG_IDLE: begin
               end
               SEG_START, SEG_RESTART: begin
                  case (sub)
                     2'd0: begin
                        ctl.scl_op = mlar_pkg::LINE_KEEP;
                        ctl.sda_op = mlar_pkg::LINE_HIGH;
                     end
                     2'd1: begin
                        ctl.scl_op = mlar_pkg::LINE_HIGH;
                        ctl.sda_op = mlar_pkg::LINE_KEEP;
                     end
                     2'd2: begin
                        ctl.scl_op = mlar_pkg::LINE_KEEP;
                        ctl.sda_op = mlar_pkg::LINE_LOW;
                     end
                     default: begin
                        ctl.scl_op = mlar_pkg::LINE_LOW;
                        ctl.sda_op = mlar_pkg::LINE_KEEP;
                     end
                  endcase
                  if (sub == 2'd3) begin
                     bc_in    = 4'd0;
                     phase_in = {seg + 4'd1, 2'd0};
                  end else begin
                     phase_in = {seg, sub + 2'd1};
                  end
               end
               SEG_STOP: begin
                  case (sub)
                     2'd0: begin
                        ctl.scl_op = mlar_pkg::LINE_KEEP;
                        ctl.sda_op = mlar_pkg::LINE_LOW;
                        phase_in   = {seg, 2'd1};
                     end
                     2'd1: begin
                        ctl.scl_op = mlar_pkg::LINE_HIGH;
                        ctl.sda_op = mlar_pkg::LINE_KEEP;
                        phase_in   = {seg, 2'd2};
                     end
                     default: begin
                        ctl.scl_op = mlar_pkg::LINE_KEEP;
                        ctl.sda_op = mlar_pkg::LINE_HIGH;
                        ctl.finish = 1'b1;
                        phase_in   = {SEG_IDLE, 2'd0};
                        bc_in      = 4'd0;
                     end
                  endcase
               end
               SEG_ADDRW, SEG_REG, SEG_ADDRR, SEG_DHI, SEG_DLO: begin
                  case (sub)
                     2'd0: begin
                        ctl.scl_op = mlar_pkg::LINE_KEEP;
                        ctl.sda_op = bit_level ? mlar_pkg::LINE_HIGH : mlar_pkg::LINE_LOW;
                        phase_in   = {seg, 2'd1};
                     end
                     2'd1: begin
                        ctl.scl_op = mlar_pkg::LINE_HIGH;
                        ctl.sda_op = mlar_pkg::LINE_KEEP;
                        phase_in   = {seg, 2'd2};
                     end
                     2'd2: begin
                        ctl.sample_ack  = is_write && bc_hi;
                        ctl.sample_data = !is_write && !bc_hi;
                        ctl.scl_op      = mlar_pkg::LINE_LOW;
                        ctl.sda_op      = mlar_pkg::LINE_KEEP;
                        if (bc_plus >= 5'd9) begin
                           bc_in    = 4'd0;
                           phase_in = {seg_after, 2'd0};
                        end else begin
                           bc_in    = bc_plus[3:0];
                           phase_in = {seg, 2'd0};
                        end
                     end
                     default: begin
                        ctl.scl_op = mlar_pkg::LINE_HIGH;
                        ctl.sda_op = mlar_pkg::LINE_HIGH;
                        phase_in   = {SEG_IDLE, 2'd0};
                        bc_in      = 4'd0;
                     end
                  endcase
               end
               default: begin
                  ctl.scl_op = mlar_pkg::LINE_HIGH;
                  ctl.sda_op = mlar_pkg::LINE_HIGH;
                  phase_in   = {SEG_IDLE, 2'd0};
                  bc_in      = 4'd0;
               end
            endcase
         end
      end
      busy_next = (phase_in[5:2] != SEG_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= {SEG_IDLE, 2'd0};
         bc_ff    <= 4'd0;
         cmd_ff   <= mlar_pkg::KIND_TICK;
      end else begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         cmd_ff   <= cmd_in;
      end
   end

   `MLAR_ASSERT_IMP(a_clear_from_idle, clock, reset, ctl.clear, phase_ff[5:2] == SEG_IDLE, "read started while busy")
   `MLAR_ASSERT_IMP(a_bit_count_range, clock, reset, phase_ff[5:2] != SEG_IDLE, bc_ff <= 4'd8, "bit count out of range")
   `MLAR_ASSERT_NXT(a_finish_idles, clock, reset, ctl.finish, phase_ff == {SEG_IDLE, 2'd0}, "sequencer not idle after stop")

endmodule

`default_nettype wire

>>> sv/mlar_lane.sv
`default_nettype none

module mlar_lane (
   input  wire                    clock,
   input  wire                    reset,
   input  wire mlar_pkg::lane_ctl_type ctl,
   input  wire                    enable,
   input  wire                    sda_bit,
   output logic                   scl_next,
   output logic                   sda_next,
   output logic                   online,
   output logic [15:0]            angle,
   output logic [1:0]             magnet
);

   logic        err_ff, err_in;
   logic [15:0] shift_ff, shift_in;
   logic        scl_line_ff, scl_line_in;
   logic        sda_line_ff, sda_line_in;
   logic        online_ff, online_in;
   logic [15:0] angle_ff, angle_in;
   logic [1:0]  magnet_ff, magnet_in;

   logic act_now;
   logic act_drive;

   always_comb begin
      act_now  = enable & ~err_ff;
      err_in   = err_ff;
      shift_in = shift_ff;
      if (ctl.clear) begin
         err_in   = 1'b0;
         shift_in = 16'd0;
      end else begin
         if (ctl.sample_ack && act_now && sda_bit) begin
            err_in = 1'b1;
         end
         if (ctl.sample_data && act_now) begin
            shift_in = {shift_ff[14:0], sda_bit};
         end
      end
      // The clock is lowered after the acknowledge sample, so a lane that just failed releases.
      act_drive   = enable & ~err_in;
      scl_line_in = mlar_pkg::line_next(scl_line_ff, act_drive, ctl.scl_op);
      sda_line_in = mlar_pkg::line_next(sda_line_ff, act_drive, ctl.sda_op);

      online_in = online_ff;
      angle_in  = angle_ff;
      magnet_in = magnet_ff;
      if (ctl.finish && enable) begin
         online_in = ~err_ff;
         if (ctl.status_read) begin
            magnet_in = err_ff ? mlar_pkg::MAG_NONE : mlar_pkg::magnet_code(shift_ff[7:0]);
         end else begin
            angle_in = err_ff ? 16'd0 : shift_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff      <= 1'b0;
         shift_ff    <= 16'd0;
         scl_line_ff <= 1'b1;
         sda_line_ff <= 1'b1;
         online_ff   <= 1'b0;
         angle_ff    <= 16'd0;
         magnet_ff   <= mlar_pkg::MAG_NONE;
      end else begin
         err_ff      <= err_in;
         shift_ff    <= shift_in;
         scl_line_ff <= scl_line_in;
         sda_line_ff <= sda_line_in;
         online_ff   <= online_in;
         angle_ff    <= angle_in;
         magnet_ff   <= magnet_in;
      end
   end

   assign scl_next = scl_line_in;
   assign sda_next = sda_line_in;
   assign online   = online_ff;
   assign angle    = angle_ff;
   assign magnet   = magnet_ff;

endmodule

`default_nettype wire

>>> sv/mlar_merge.sv
`default_nettype none
`include "multi_lane_i2c_angle_reader_defines.svh"

module mlar_merge (
   input  wire               clock,
   input  wire               reset,
   input  wire               load,
   input  wire  [7:0]        scl_line,
   input  wire  [7:0]        sda_line,
   input  wire               busy,
   input  wire               finish,
   input  wire  [7:0]        report_mask,
   input  wire  [7:0]        lane_online,
   input  wire  [7:0][15:0]  lane_angle,
   input  wire  [7:0][1:0]   lane_magnet,
   output logic              in_ready,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  scl_ff, scl_in;
   logic [7:0]  sda_ff, sda_in;
   logic        busy_ff, busy_in;
   logic        rv_ff, rv_in;
   logic [2:0]  lane_ff, lane_in;
   logic        online_ff, online_in;
   logic [15:0] angle_ff, angle_in;
   logic [1:0]  magnet_ff, magnet_in;
   logic        last_ff, last_in;

   logic       take;
   logic [2:0] sel;
   logic [7:0] pend_rest;

   always_comb begin
      sel = 3'd0;
      for (int i = mlar_pkg::LANE_MAX - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = 3'(i);
         end
      end
      pend_rest = pend_ff & ~(8'd1 << sel);
   end

   assign take     = valid_ff && rsp_tready;
   assign in_ready = !valid_ff || (rsp_tready && (pend_ff == 8'd0));

   always_comb begin
      valid_in  = valid_ff;
      pend_in   = pend_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      busy_in   = busy_ff;
      rv_in     = rv_ff;
      lane_in   = lane_ff;
      online_in = online_ff;
      angle_in  = angle_ff;
      magnet_in = magnet_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         pend_in   = finish ? report_mask : 8'd0;
         scl_in    = scl_line;
         sda_in    = sda_line;
         busy_in   = busy;
         rv_in     = 1'b0;
         lane_in   = 3'd0;
         online_in = 1'b0;
         angle_in  = 16'd0;
         magnet_in = mlar_pkg::MAG_NONE;
         last_in   = 1'b0;
      end else if (take) begin
         if (pend_ff != 8'd0) begin
            scl_in    = mlar_pkg::LINES_RELEASED;
            sda_in    = mlar_pkg::LINES_RELEASED;
            busy_in   = 1'b0;
            rv_in     = 1'b1;
            lane_in   = sel;
            online_in = lane_online[sel];
            angle_in  = lane_angle[sel];
            magnet_in = lane_magnet[sel];
            last_in   = (pend_rest == 8'd0);
            pend_in   = pend_rest;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 8'd0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scl_ff    <= scl_in;
      sda_ff    <= sda_in;
      busy_ff   <= busy_in;
      rv_ff     <= rv_in;
      lane_ff   <= lane_in;
      online_ff <= online_in;
      angle_ff  <= angle_in;
      magnet_ff <= magnet_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, magnet_ff, angle_ff, online_ff, lane_ff, busy_ff, sda_ff, scl_ff};
   assign rsp_tuser  = rv_ff;
   assign rsp_tlast  = last_ff;

   `MLAR_ASSERT_NXT(a_load_shows, clock, reset, load, valid_ff, "loaded item not presented")
   `MLAR_ASSERT_IMP(a_last_drained, clock, reset, valid_ff && last_ff, pend_ff == 8'd0, "reports pending after last")
   `MLAR_ASSERT_IMP(a_pend_valid, clock, reset, pend_ff != 8'd0, valid_ff && !in_ready, "pending reports without output")

endmodule

`default_nettype wire
